/* design/feature_ring_minmax_quantizer_core_macros.svh */
// Assertion macros for the feature ring min/max quantizer.
// Expects clk and arst_n in scope at the point of use; no other dependencies.
`ifndef FEATURE_RING_MINMAX_QUANTIZER_CORE_MACROS_SVH
`define FEATURE_RING_MINMAX_QUANTIZER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FRMQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frmq: same-cycle check failed");
`define FRMQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frmq: next-cycle check failed");
`else
`define FRMQ_ASSERT_IMP(lbl, ante, cons)
`define FRMQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* design/frmq_pkg.sv */
// Shared types and constants for the feature ring min/max quantizer.
// No dependencies; imported by every module of the block.
package frmq_pkg;

	localparam int REQ_W      = 2;
	localparam int ROW_W      = 5;
	localparam int FRAME_W    = 6;
	localparam int STAT_W     = 2;
	localparam int Q_W        = 8;
	localparam int DIM_W      = 6;
	localparam int FRM_W      = 7;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 7;
	localparam int QDEPTH     = 2;

	localparam int DIMS_RESET   = 13;
	localparam int FRAMES_RESET = 32;

	localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SCAN = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NO_SCAN  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_DIMS   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 4'd1;

	typedef enum logic [1:0] {
		OP_PUSH,
		OP_SCAN,
		OP_READ,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic               in_range;
		logic [ROW_W-1:0]   row;
		logic [FRAME_W-1:0] frame;
	} item_ctl_t;

	typedef struct packed {
		logic [DIM_W-1:0] dims;
		logic [FRM_W-1:0] frames;
	} cfg_t;

endpackage

/* design/frmq_front.sv */
// Front stage: takes input words, decodes the request and checks read indices.
// Depends on frmq_pkg; feeds frmq_queue.
module frmq_front #(
	parameter int COEF_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [frmq_pkg::REQ_W-1:0]     req_type,
	input  logic signed [COEF_WIDTH-1:0]   coefficient,
	input  logic [frmq_pkg::ROW_W-1:0]     row_index,
	input  logic [frmq_pkg::FRAME_W-1:0]   frame_index,
	input  frmq_pkg::cfg_t                 cfg,
	output logic                           item_valid,
	input  logic                           item_ready,
	output frmq_pkg::item_ctl_t            item_ctl,
	output logic [COEF_WIDTH-1:0]          item_coef
);
	import frmq_pkg::*;

	logic      vld_s1;
	item_ctl_t ctl_s1;
	logic [COEF_WIDTH-1:0] coef_s1;
	item_ctl_t ctl_d;
	logic      take;

	assign in_ready = !vld_s1 || item_ready;
	assign take     = in_valid && in_ready;

	always_comb begin
		ctl_d.row   = row_index;
		ctl_d.frame = frame_index;
		ctl_d.in_range = (DIM_W'(row_index) < cfg.dims) &&
			(FRM_W'(frame_index) < cfg.frames);
		unique case (req_type)
			REQ_PUSH: ctl_d.op = OP_PUSH;
			REQ_SCAN: ctl_d.op = OP_SCAN;
			REQ_READ: ctl_d.op = OP_READ;
			default:  ctl_d.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (item_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctl_s1  <= ctl_d;
			coef_s1 <= coefficient;
		end
	end

	assign item_valid = vld_s1;
	assign item_ctl   = ctl_s1;
	assign item_coef  = coef_s1;

endmodule

/* design/frmq_queue.sv */
// Short FIFO between the front and back stages.
// Depends on frmq_pkg for its depth.
module frmq_queue #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr_valid,
	output logic         wr_ready,
	input  logic [W-1:0] wr_data,
	output logic         rd_valid,
	input  logic         rd_ready,
	output logic [W-1:0] rd_data
);
	import frmq_pkg::*;

	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	logic [W-1:0]  slot_q [QDEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(QDEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ready = (cnt_q != CW'(QDEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= ptr_inc(wptr_q);
			if (pop)
				rptr_q <= ptr_inc(rptr_q);
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= wr_data;
	end

endmodule

/* design/frmq_div.sv */
// Restoring divider, one quotient bit per cycle, for the byte scaling.
// Depends on frmq_pkg; quotient must fit in Q_W bits (num < den << Q_W).
module frmq_div #(
	parameter int SPAN_W = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [SPAN_W+frmq_pkg::Q_W-1:0] num,
	input  logic [SPAN_W-1:0]             den,
	output logic                          done,
	output logic [frmq_pkg::Q_W-1:0]      quot
);
	import frmq_pkg::*;

	localparam int NUM_W = SPAN_W + Q_W;
	localparam int CNT_W = (Q_W > 1) ? $clog2(Q_W) : 1;

	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-2:0] dsh_q;
	logic [Q_W-1:0]   quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q;
	logic             ge;

	assign ge = rem_q >= {1'b0, dsh_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(Q_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// divisor starts aligned to the top quotient bit and walks down
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= {den, (Q_W - 1)'(0)};
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - {1'b0, dsh_q};
			quot_q <= {quot_q[Q_W-2:0], ge};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

/* design/frmq_back.sv */
// Back stage: owns the column memory, ring pointers, config and range state,
// executes push/scan/read words and holds the result register. Uses frmq_pkg, frmq_div.
module frmq_back #(
	parameter int MAX_DIMS   = 32,
	parameter int MAX_FRAMES = 64,
	parameter int COEF_WIDTH = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [frmq_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [frmq_pkg::CFG_DATA_W-1:0]   cfg_data,
	output frmq_pkg::cfg_t                    cfg,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  frmq_pkg::item_ctl_t               item_ctl,
	input  logic [COEF_WIDTH-1:0]             item_coef,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [frmq_pkg::STAT_W-1:0]       status,
	output logic [frmq_pkg::Q_W-1:0]          quantized_value,
	output logic                              window_full
);
	import frmq_pkg::*;

	localparam int RING_COLS = MAX_FRAMES + 2;
	localparam int DEPTH     = MAX_DIMS * RING_COLS;
	localparam int AW        = $clog2(DEPTH);
	localparam int RING_W    = FRM_W + 1;
	localparam int CNT_W     = $clog2(RING_COLS + 1);
	localparam int CMP_W     = (CNT_W > FRM_W) ? CNT_W : FRM_W;
	localparam int SPAN_W    = COEF_WIDTH + 1;
	localparam int NUM_W     = SPAN_W + Q_W;
	localparam int DIMS_INIT   = (DIMS_RESET > MAX_DIMS) ? MAX_DIMS : DIMS_RESET;
	localparam int FRAMES_INIT = (FRAMES_RESET > MAX_FRAMES) ? MAX_FRAMES : FRAMES_RESET;

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SCAN     = 3'd1;
	localparam logic [2:0] ST_SCAN_END = 3'd2;
	localparam logic [2:0] ST_RD_MEM   = 3'd3;
	localparam logic [2:0] ST_DIV      = 3'd4;

	logic [2:0]        state_q;
	logic [DIM_W-1:0]  dims_q;
	logic [FRM_W-1:0]  frames_q;
	logic [RING_W-1:0] wcol_q;
	logic [DIM_W-1:0]  wrow_q;
	logic [CNT_W-1:0]  pushed_q;
	logic signed [COEF_WIDTH-1:0] lo_q, hi_q;
	logic              rvalid_q;

	logic [RING_W-1:0] scol_q;
	logic [DIM_W-1:0]  srow_q;
	logic [FRM_W-1:0]  sfrm_q;
	logic              first_q;
	logic              dvld_s1;

	logic [COEF_WIDTH-1:0] col_mem_q [DEPTH];
	logic [COEF_WIDTH-1:0] rd_q;

	logic              out_vld_q;
	logic [STAT_W-1:0] stat_q;
	logic [Q_W-1:0]    qv_q;
	logic              full_q;

	// config decode
	logic [DIM_W-1:0]  dims_new;
	logic [FRM_W-1:0]  frames_new;
	logic              wr_dims, wr_frames, restart;

	// execution control
	logic              out_free, pop;
	logic              push_do, scan_start, rd_issue, div_start;
	logic              res_load;
	logic [STAT_W-1:0] res_status;
	logic [Q_W-1:0]    res_q;
	logic              full_now, full_d;
	logic              row_wrap;
	logic [RING_W-1:0] ring, col_next;
	logic [CNT_W-1:0]  pushed_d;
	logic [RING_W:0]   ssum, rsum;
	logic [RING_W-1:0] scan_col0, rcol;
	logic              scan_last;
	logic [AW-1:0]     waddr, raddr, scan_addr, read_addr;

	// read scaling
	logic signed [COEF_WIDTH-1:0] x;
	logic [SPAN_W-1:0] span, off;
	logic [NUM_W-1:0]  num;
	logic              div_done;
	logic [Q_W-1:0]    div_quot;

	// ---- configuration ----
	always_comb begin
		if (cfg_data[DIM_W-1:0] == '0)
			dims_new = DIM_W'(1);
		else if (32'(cfg_data[DIM_W-1:0]) > MAX_DIMS)
			dims_new = DIM_W'(MAX_DIMS);
		else
			dims_new = cfg_data[DIM_W-1:0];

		if (cfg_data[FRM_W-1:0] == '0)
			frames_new = FRM_W'(1);
		else if (32'(cfg_data[FRM_W-1:0]) > MAX_FRAMES)
			frames_new = FRM_W'(MAX_FRAMES);
		else
			frames_new = cfg_data[FRM_W-1:0];
	end

	assign cfg_ready = 1'b1;
	assign wr_dims   = cfg_valid && (cfg_index == CFG_DIMS) && (dims_new != dims_q);
	assign wr_frames = cfg_valid && (cfg_index == CFG_FRAMES) && (frames_new != frames_q);
	assign restart   = wr_dims || wr_frames;
	assign cfg.dims   = dims_q;
	assign cfg.frames = frames_q;

	// ---- ring arithmetic ----
	assign ring      = RING_W'(frames_q) + RING_W'(2);
	assign row_wrap  = ({1'b0, wrow_q} + 1'b1) >= {1'b0, dims_q};
	assign col_next  = ((wcol_q + 1'b1) >= ring) ? '0 : wcol_q + 1'b1;
	assign full_now  = CMP_W'(pushed_q) >= CMP_W'(frames_q);

	// oldest window column sits two past the write column
	assign ssum      = {1'b0, wcol_q} + (RING_W + 1)'(2);
	assign scan_col0 = (ssum >= {1'b0, ring}) ? RING_W'(ssum - {1'b0, ring}) : RING_W'(ssum);
	assign rsum      = {1'b0, wcol_q} + (RING_W + 1)'(2) + (RING_W + 1)'(item_ctl.frame);
	assign rcol      = (rsum >= {1'b0, ring}) ? RING_W'(rsum - {1'b0, ring}) : RING_W'(rsum);

	assign waddr     = AW'(wcol_q * MAX_DIMS + wrow_q);
	assign scan_addr = AW'(scol_q * MAX_DIMS + srow_q);
	assign read_addr = AW'(rcol * MAX_DIMS + item_ctl.row);
	assign raddr     = (state_q == ST_SCAN) ? scan_addr : read_addr;
	assign scan_last = (srow_q == dims_q - 1'b1) && (sfrm_q == frames_q - 1'b1);

	// ---- read scaling ----
	assign x    = signed'(rd_q);
	assign span = {hi_q[COEF_WIDTH-1], hi_q} - {lo_q[COEF_WIDTH-1], lo_q};
	assign off  = (x > lo_q) ? ({x[COEF_WIDTH-1], x} - {lo_q[COEF_WIDTH-1], lo_q}) : '0;
	assign num  = {off, Q_W'(0)} - NUM_W'(off);

	// ---- dispatch and result selection ----
	assign out_free   = !out_vld_q || out_ready;
	assign item_ready = (state_q == ST_IDLE) && out_free;
	assign pop        = item_valid && item_ready;

	always_comb begin
		push_do    = 1'b0;
		scan_start = 1'b0;
		rd_issue   = 1'b0;
		div_start  = 1'b0;
		res_load   = 1'b0;
		res_status = STAT_OK;
		res_q      = '0;
		if (pop) begin
			unique case (item_ctl.op)
				OP_PUSH: begin
					push_do  = 1'b1;
					res_load = 1'b1;
				end
				OP_SCAN: begin
					if (!full_now) begin
						res_load   = 1'b1;
						res_status = STAT_NOT_FULL;
					end else begin
						scan_start = 1'b1;
					end
				end
				OP_READ: begin
					priority if (!full_now) begin
						res_load   = 1'b1;
						res_status = STAT_NOT_FULL;
					end else if (!item_ctl.in_range) begin
						res_load   = 1'b1;
						res_status = STAT_RANGE;
					end else if (!rvalid_q) begin
						res_load   = 1'b1;
						res_status = STAT_NO_SCAN;
					end else begin
						rd_issue = 1'b1;
					end
				end
				OP_NOP: res_load = 1'b1;
			endcase
		end
		if (state_q == ST_SCAN_END)
			res_load = 1'b1;
		if (state_q == ST_RD_MEM) begin
			priority if (!(hi_q > lo_q)) begin
				res_load = 1'b1;
			end else if (off >= span) begin
				res_load = 1'b1;
				res_q    = '1;
			end else begin
				div_start = 1'b1;
			end
		end
		if ((state_q == ST_DIV) && div_done) begin
			res_load = 1'b1;
			res_q    = div_quot;
		end
	end

	assign pushed_d = (push_do && row_wrap && (pushed_q < CNT_W'(RING_COLS))) ?
		pushed_q + 1'b1 : pushed_q;
	assign full_d   = CMP_W'(pushed_d) >= CMP_W'(frames_q);

	// ---- control state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			dims_q   <= DIM_W'(DIMS_INIT);
			frames_q <= FRM_W'(FRAMES_INIT);
			wcol_q   <= '0;
			wrow_q   <= '0;
			pushed_q <= '0;
			rvalid_q <= 1'b0;
			lo_q     <= '0;
			hi_q     <= '0;
			scol_q   <= '0;
			srow_q   <= '0;
			sfrm_q   <= '0;
			first_q  <= 1'b0;
			dvld_s1  <= 1'b0;
		end else begin
			if (wr_dims)
				dims_q <= dims_new;
			if (wr_frames)
				frames_q <= frames_new;

			if (restart) begin
				wcol_q   <= '0;
				wrow_q   <= '0;
				pushed_q <= '0;
				rvalid_q <= 1'b0;
			end else if (push_do) begin
				pushed_q <= pushed_d;
				if (row_wrap) begin
					wrow_q   <= '0;
					wcol_q   <= col_next;
					rvalid_q <= 1'b0;
				end else begin
					wrow_q <= wrow_q + 1'b1;
				end
			end else if (state_q == ST_SCAN_END) begin
				rvalid_q <= 1'b1;
			end

			dvld_s1 <= (state_q == ST_SCAN);
			if (dvld_s1) begin
				if (first_q || (x < lo_q))
					lo_q <= x;
				if (first_q || (x > hi_q))
					hi_q <= x;
				first_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (scan_start) begin
						state_q <= ST_SCAN;
						scol_q  <= scan_col0;
						srow_q  <= '0;
						sfrm_q  <= '0;
						first_q <= 1'b1;
					end else if (rd_issue) begin
						state_q <= ST_RD_MEM;
					end
				end
				ST_SCAN: begin
					if (srow_q == dims_q - 1'b1) begin
						srow_q <= '0;
						sfrm_q <= sfrm_q + 1'b1;
						scol_q <= ((scol_q + 1'b1) >= ring) ? '0 : scol_q + 1'b1;
					end else begin
						srow_q <= srow_q + 1'b1;
					end
					if (scan_last)
						state_q <= ST_SCAN_END;
				end
				ST_SCAN_END: state_q <= ST_IDLE;
				ST_RD_MEM:   state_q <= div_start ? ST_DIV : ST_IDLE;
				ST_DIV: begin
					if (div_done)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---- column memory: one write, one registered read ----
	always_ff @(posedge clk) begin
		if (push_do)
			col_mem_q[waddr] <= item_coef;
		rd_q <= col_mem_q[raddr];
	end

	frmq_div #(
		.SPAN_W(SPAN_W)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (num),
		.den   (span),
		.done  (div_done),
		.quot  (div_quot)
	);

	// ---- result register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			stat_q <= res_status;
			qv_q   <= res_q;
			full_q <= full_d;
		end
	end

	assign out_valid       = out_vld_q;
	assign status          = stat_q;
	assign quantized_value = qv_q;
	assign window_full     = full_q;

endmodule

/* design/feature_ring_minmax_quantizer_core.sv */
// Top level of the feature ring min/max quantizer: front decode, word queue, back stage.
// Depends on frmq_pkg, frmq_front, frmq_queue, frmq_back and the assertion macro header.
//
// Push words store one coefficient each into a ring of frames_in_window+2 columns held
// in a single-port-write, single-port-read memory of MAX_DIMS*(MAX_FRAMES+2) words that
// has no reset: entries are undefined until pushed. A push, an unknown request or any
// request rejected by a status check is answered straight from the idle back stage, so
// these run at one word per cycle while out_ready holds; an accepted input word passes
// the front register and the word queue before its result enters the result register.
// A scan walks the window through the one memory read port, one entry per cycle. A
// successful read accesses the memory, then runs the bit-serial divider when the scanned
// maximum exceeds the minimum and the value lies below the maximum. Configuration writes
// are accepted every cycle and must only be issued while the block is idle.
`include "feature_ring_minmax_quantizer_core_macros.svh"

module feature_ring_minmax_quantizer_core #(
	parameter int MAX_DIMS   = 32,
	parameter int MAX_FRAMES = 64,
	parameter int COEF_WIDTH = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [frmq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [frmq_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [frmq_pkg::REQ_W-1:0]      req_type,
	input  logic signed [COEF_WIDTH-1:0]    coefficient,
	input  logic [frmq_pkg::ROW_W-1:0]      row_index,
	input  logic [frmq_pkg::FRAME_W-1:0]    frame_index,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [frmq_pkg::STAT_W-1:0]     status,
	output logic [frmq_pkg::Q_W-1:0]        quantized_value,
	output logic                            window_full
);
	import frmq_pkg::*;

	localparam int ITEM_W = $bits(item_ctl_t) + COEF_WIDTH;

	cfg_t                  cfg;
	logic                  f_valid, f_ready;
	item_ctl_t             f_ctl;
	logic [COEF_WIDTH-1:0] f_coef;
	logic                  q_valid, q_ready;
	logic [ITEM_W-1:0]     q_data;
	item_ctl_t             q_ctl;
	logic [COEF_WIDTH-1:0] q_coef;
	logic                  q_pop;

	frmq_front #(
		.COEF_WIDTH(COEF_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.coefficient(coefficient),
		.row_index  (row_index),
		.frame_index(frame_index),
		.cfg        (cfg),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item_ctl   (f_ctl),
		.item_coef  (f_coef)
	);

	frmq_queue #(
		.W(ITEM_W)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(f_valid),
		.wr_ready(f_ready),
		.wr_data ({f_ctl, f_coef}),
		.rd_valid(q_valid),
		.rd_ready(q_ready),
		.rd_data (q_data)
	);

	assign {q_ctl, q_coef} = q_data;
	assign q_pop = q_valid && q_ready;

	frmq_back #(
		.MAX_DIMS  (MAX_DIMS),
		.MAX_FRAMES(MAX_FRAMES),
		.COEF_WIDTH(COEF_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cfg            (cfg),
		.item_valid     (q_valid),
		.item_ready     (q_ready),
		.item_ctl       (q_ctl),
		.item_coef      (q_coef),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.quantized_value(quantized_value),
		.window_full    (window_full)
	);

	// error results never carry a byte, and a scaled byte implies a full window
	`FRMQ_ASSERT_IMP(a_err_no_byte, out_valid && (status != STAT_OK), quantized_value == '0)
	`FRMQ_ASSERT_IMP(a_byte_needs_full, out_valid && (quantized_value != '0), window_full)
	`FRMQ_ASSERT_IMP(a_not_full_flag, out_valid && (status == STAT_NOT_FULL), !window_full)
	// back only takes a word when the result register can accept its result
	`FRMQ_ASSERT_IMP(a_pop_out_free, q_pop, !out_valid || out_ready)
	`FRMQ_ASSERT_NXT(a_push_result, q_pop && (q_ctl.op == OP_PUSH), out_valid)

endmodule
